[src/utf8_bytewise_decoder_assert.svh]
// Assertion macros shared by the utf8 decoder modules.
`ifndef UTF8_BYTEWISE_DECODER_ASSERT_SVH
`define UTF8_BYTEWISE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define UBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UBD_ASSERT(lbl, prop, msg)
`define UBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/utf8d_pkg.sv]
// Shared types and constants of the utf8 bytewise decoder.
`default_nettype none
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 16;
  localparam int unsigned LenW   = 3;

  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  localparam logic [LenW-1:0] Len0 = 3'd0;
  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_READY   = 2'd1,
    ST_DISCARD = 2'd2,
    ST_SKIP4   = 2'd3
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [CpW-1:0]   code_point;
  } res_t;

endpackage
`default_nettype wire

[src/utf8d_core.sv]
// Decode state registers and the per-beat next-state and result logic.
`default_nettype none
`include "utf8_bytewise_decoder_assert.svh"
module utf8d_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_fire_i,
  input  wire logic [utf8d_pkg::ByteW-1:0] in_byte_i,
  output utf8d_pkg::res_t                  res_o
);

  logic [utf8d_pkg::LenW-1:0] exp_q, exp_d;
  logic [utf8d_pkg::LenW-1:0] seen_q, seen_d;
  logic [utf8d_pkg::CpW-1:0]  acc_q, acc_d;
  logic [utf8d_pkg::LenW-1:0] seen_inc;
  logic [utf8d_pkg::CpW-1:0]  acc_shift;
  logic                       is_idle;

  assign is_idle   = (seen_q == utf8d_pkg::Len0) || (exp_q == utf8d_pkg::Len0);
  assign seen_inc  = seen_q + utf8d_pkg::Len1;
  assign acc_shift = {acc_q[utf8d_pkg::CpW-7:0], in_byte_i[5:0]};

  always_comb begin
    exp_d            = exp_q;
    seen_d           = seen_q;
    acc_d            = acc_q;
    res_o.status     = utf8d_pkg::ST_PENDING;
    res_o.code_point = '0;
    if (is_idle) begin
      exp_d  = utf8d_pkg::Len0;
      seen_d = utf8d_pkg::Len0;
      acc_d  = '0;
      priority if (!in_byte_i[7]) begin
        res_o.status     = utf8d_pkg::ST_READY;
        res_o.code_point = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, in_byte_i};
      end else if ((in_byte_i & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Code) begin
        exp_d  = utf8d_pkg::Len2;
        seen_d = utf8d_pkg::Len1;
        acc_d  = {{(utf8d_pkg::CpW-5){1'b0}}, in_byte_i[4:0]};
      end else if ((in_byte_i & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Code) begin
        exp_d  = utf8d_pkg::Len3;
        seen_d = utf8d_pkg::Len1;
        acc_d  = {{(utf8d_pkg::CpW-4){1'b0}}, in_byte_i[3:0]};
      end else if ((in_byte_i & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Code) begin
        exp_d  = utf8d_pkg::Len4;
        seen_d = utf8d_pkg::Len1;
        acc_d  = {{(utf8d_pkg::CpW-3){1'b0}}, in_byte_i[2:0]};
      end else begin
        res_o.status = utf8d_pkg::ST_DISCARD;
      end
    end else if ((in_byte_i & utf8d_pkg::ContMask) == utf8d_pkg::ContCode) begin
      seen_d = seen_inc;
      acc_d  = acc_shift;
      if (seen_inc >= exp_q) begin
        if (exp_q == utf8d_pkg::Len4) begin
          res_o.status = utf8d_pkg::ST_SKIP4;
        end else begin
          res_o.status     = utf8d_pkg::ST_READY;
          res_o.code_point = acc_shift;
        end
        exp_d  = utf8d_pkg::Len0;
        seen_d = utf8d_pkg::Len0;
        acc_d  = '0;
      end
    end else begin
      res_o.status = utf8d_pkg::ST_DISCARD;
      exp_d        = utf8d_pkg::Len0;
      seen_d       = utf8d_pkg::Len0;
      acc_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= utf8d_pkg::Len0;
      seen_q <= utf8d_pkg::Len0;
      acc_q  <= '0;
    end else if (in_fire_i) begin
      exp_q  <= exp_d;
      seen_q <= seen_d;
      acc_q  <= acc_d;
    end
  end

  `UBD_ASSERT_ALWAYS(a_open_consistent,
    (exp_q != utf8d_pkg::Len0) |-> (seen_q != utf8d_pkg::Len0 && seen_q < exp_q),
    "open sequence count out of range")
  `UBD_ASSERT_ALWAYS(a_idle_clean,
    (exp_q == utf8d_pkg::Len0) |-> (seen_q == utf8d_pkg::Len0 && acc_q == '0),
    "idle state not cleared")
  `UBD_ASSERT(a_ascii_ready,
    (in_fire_i && is_idle && !in_byte_i[7]) |-> (res_o.status == utf8d_pkg::ST_READY),
    "ascii byte not emitted")

endmodule
`default_nettype wire

[src/utf8d_obuf.sv]
// Result register with a skid stage toward the output channel.
`default_nettype none
`include "utf8_bytewise_decoder_assert.svh"
module utf8d_obuf (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_fire_i,
  input  wire utf8d_pkg::res_t            res_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      status_o,
  output logic [utf8d_pkg::CpW-1:0]       code_point_o
);

  logic            main_valid_q;
  logic            skid_valid_q;
  utf8d_pkg::res_t main_q;
  utf8d_pkg::res_t skid_q;
  logic            out_fire;

  assign out_fire     = main_valid_q && !out_stall_i;
  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign status_o     = main_q.status;
  assign code_point_o = main_q.code_point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_fire_i) begin
      if (!main_valid_q || out_fire) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      if (!main_valid_q || out_fire) begin
        main_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end else if (out_fire && skid_valid_q) begin
      main_q <= skid_q;
    end
  end

  `UBD_ASSERT_ALWAYS(a_skid_needs_main, skid_valid_q |-> main_valid_q,
    "skid beat without main beat")
  `UBD_ASSERT(a_code_only_ready,
    (main_valid_q && main_q.status != utf8d_pkg::ST_READY) |-> (main_q.code_point == '0),
    "code point set on a non-ready beat")
  `UBD_ASSERT(a_skid_fill,
    (in_fire_i && main_valid_q && out_stall_i) |=> skid_valid_q,
    "stalled beat not parked in skid")

endmodule
`default_nettype wire

[src/utf8_bytewise_decoder.sv]
// Top level of the bytewise UTF-8 decoder for the basic multilingual plane.
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | in_byte_i
//   out     | output    | out_valid_o / out_stall_i| status_o, code_point_o
// One byte is accepted per cycle while in_stall_o is low; its result is registered.
// Every accepted byte gives exactly one result beat.
// A two-entry output buffer (result register plus skid) decouples the sides.
// in_stall_o rises only when the output has been stalled with both entries full.
// Reset clears the decode state and empties the output buffer.
`default_nettype none
module utf8_bytewise_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [utf8d_pkg::ByteW-1:0] in_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic [utf8d_pkg::CpW-1:0]        code_point_o
);

  logic            in_fire;
  utf8d_pkg::res_t res;

  assign in_fire = in_valid_i && !in_stall_o;

  utf8d_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_byte_i (in_byte_i),
    .res_o     (res)
  );

  utf8d_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .res_i        (res),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .code_point_o (code_point_o)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the bytewise UTF-8 decoder with random pacing on both channels.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         RunLimit   = 5ms;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned HoldCyc    = 60;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [utf8d_pkg::ByteW-1:0]     in_byte_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      status_o;
  logic [utf8d_pkg::CpW-1:0]       code_point_o;

  utf8d_pkg::res_t                 pending_results[$];
  logic [utf8d_pkg::LenW-1:0]      seq_len;
  logic [utf8d_pkg::LenW-1:0]      seq_seen;
  logic [utf8d_pkg::CpW-1:0]       cp_acc;

  bit                   tx_idle_en;
  bit                   rx_idle_en;
  int unsigned          hold_req;
  int unsigned          bytes_sent;
  int unsigned          err_count;
  int unsigned          in_stall_cycles;
  int unsigned          status_hits[4];

  utf8_bytewise_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .code_point_o(code_point_o)
  );

  initial begin
    forever #5ns clk_i = ~clk_i;
  end

  initial begin
    #RunLimit;
    $display("utf8_bytewise_decoder verification failed");
    $finish;
  end

  function automatic void clear_sequence();
    seq_len  = utf8d_pkg::Len0;
    seq_seen = utf8d_pkg::Len0;
    cp_acc   = '0;
  endfunction

  function automatic utf8d_pkg::res_t decode_byte(input logic [utf8d_pkg::ByteW-1:0] b);
    utf8d_pkg::res_t r;
    r.status     = utf8d_pkg::ST_PENDING;
    r.code_point = '0;
    if (seq_seen == utf8d_pkg::Len0 || seq_len == utf8d_pkg::Len0) begin
      clear_sequence();
      if (b[7] == 1'b0) begin
        r.status     = utf8d_pkg::ST_READY;
        r.code_point = {8'h00, b};
      end else if ((b & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Code) begin
        seq_len  = utf8d_pkg::Len2;
        seq_seen = utf8d_pkg::Len1;
        cp_acc   = {11'b0, b[4:0]};
      end else if ((b & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Code) begin
        seq_len  = utf8d_pkg::Len3;
        seq_seen = utf8d_pkg::Len1;
        cp_acc   = {12'b0, b[3:0]};
      end else if ((b & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Code) begin
        seq_len  = utf8d_pkg::Len4;
        seq_seen = utf8d_pkg::Len1;
        cp_acc   = {13'b0, b[2:0]};
      end else begin
        r.status = utf8d_pkg::ST_DISCARD;
      end
    end else if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContCode) begin
      seq_seen = seq_seen + utf8d_pkg::Len1;
      cp_acc   = {cp_acc[utf8d_pkg::CpW-7:0], b[5:0]};
      if (seq_seen >= seq_len) begin
        if (seq_len == utf8d_pkg::Len4) begin
          r.status = utf8d_pkg::ST_SKIP4;
        end else begin
          r.status     = utf8d_pkg::ST_READY;
          r.code_point = cp_acc;
        end
        clear_sequence();
      end
    end else begin
      r.status = utf8d_pkg::ST_DISCARD;
      clear_sequence();
    end
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk_i) begin
    utf8d_pkg::res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) begin
        in_stall_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        status_hits[status_o]++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: status=%0d code_point=%h",
                               status_o, code_point_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            flag_error($sformatf("status expected %0d actual %0d", want.status, status_o));
          end
          if (code_point_o !== want.code_point) begin
            flag_error($sformatf("code_point expected %h actual %h",
                                 want.code_point, code_point_o));
          end
        end
      end
    end
  end

  initial begin : rx_pacing
    int unsigned len;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        len      = hold_req;
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [utf8d_pkg::ByteW-1:0] b);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(decode_byte(b));
    bytes_sent++;
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
  endtask

  task automatic send_random_symbol();
    int unsigned                  kind;
    int unsigned                  len;
    int unsigned                  cut;
    logic [utf8d_pkg::ByteW-1:0]  lead;
    logic [utf8d_pkg::ByteW-1:0]  brk;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    case (len)
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    if (kind < 35) begin
      send_byte({1'b0, 7'($urandom)});
    end else if (kind < 88) begin
      send_byte(lead);
      for (int i = 1; i < len; i++) send_byte({2'b10, 6'($urandom)});
    end else if (kind < 95) begin
      cut = $urandom_range(1, len - 1);
      brk = 8'($urandom);
      if (brk[7:6] == 2'b10) begin
        brk[6] = 1'b1;
      end
      send_byte(lead);
      for (int i = 1; i < cut; i++) send_byte({2'b10, 6'($urandom)});
      send_byte(brk);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic do_reset();
    clear_sequence();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [utf8d_pkg::ByteW-1:0] seq[$];
    seq = '{8'h00, 8'h7F,
            8'hC2, 8'hA9, 8'hDF, 8'hBF,
            8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF,
            8'hF0, 8'h9F, 8'h98, 8'h80,
            8'h80, 8'hBF, 8'hF8, 8'hFF,
            8'hC3, 8'h41, 8'hE2, 8'h82, 8'hC3};
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    foreach (seq[i]) send_byte(seq[i]);
    drain_results();
  endtask

  task automatic test_backpressure();
    int unsigned start;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = HoldCyc;
    start      = bytes_sent;
    while (bytes_sent - start < 40) send_random_symbol();
    drain_results();
  endtask

  task automatic test_random_stream(input int unsigned count);
    int unsigned start;
    int unsigned mark;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    start      = bytes_sent;
    mark       = bytes_sent;
    while (bytes_sent - start < count) begin
      send_random_symbol();
      if (bytes_sent - mark >= 250) begin
        drain_results();
        mark = bytes_sent;
      end
    end
    drain_results();
  endtask

  task automatic test_full_rate(input int unsigned count);
    int unsigned start;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    start      = bytes_sent;
    while (bytes_sent - start < count) send_random_symbol();
    drain_results();
  endtask

  initial begin
    do_reset();
    test_directed();
    test_backpressure();
    test_random_stream(1380);
    test_full_rate(110);
    repeat (SettleCyc) @(posedge clk_i);
    $display("Run covered %0d bytes: %0d code points, %0d discards, %0d four-byte skips.",
             bytes_sent, status_hits[utf8d_pkg::ST_READY], status_hits[utf8d_pkg::ST_DISCARD],
             status_hits[utf8d_pkg::ST_SKIP4]);
    $display("Input was held off for %0d cycles; %0d mismatches seen.",
             in_stall_cycles, err_count);
    if (err_count == 0) begin
      $display("utf8_bytewise_decoder verification clean");
    end else begin
      $display("utf8_bytewise_decoder verification failed");
    end
    $finish;
  end

endmodule

[utf8_bytewise_decoder.f]
+incdir+src
src/utf8d_pkg.sv
src/utf8d_core.sv
src/utf8d_obuf.sv
src/utf8_bytewise_decoder.sv
tb/tb.sv
